// File: rtl/sgn_pkg.sv
package sgn_pkg;

  localparam int MAX_ROWS   = 256;
  localparam int MAX_COLS   = 256;
  localparam int ROW_W      = $clog2(MAX_ROWS);
  localparam int COL_W      = $clog2(MAX_COLS);
  localparam int PIX_W      = 8;
  localparam int SIZE_W     = 9;
  localparam int THR_W      = 17;
  localparam int GRAD_W     = 11;
  localparam int SQ_W       = 22;
  localparam int ROOT_W     = 11;
  localparam int OUT_W      = 16;
  localparam int FRAC_W     = 14;
  localparam int Q14_ONE    = 16384;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 17;
  localparam int CMD_DEPTH  = 4;
  localparam int CMD_PTR_W  = $clog2(CMD_DEPTH);

  localparam logic [CFG_IDX_W-1:0] CFG_ROWS   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COLS   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_THRESH = 2'd2;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_READ = 1'b1;

  typedef struct packed {
    logic             op;
    logic [PIX_W-1:0] pixel;
  } in_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] grad_down;
    logic signed [OUT_W-1:0] grad_right;
    logic                    suppressed;
    logic                    frame_last;
  } res_t;

  typedef struct packed {
    logic             is_read;
    logic [PIX_W-1:0] pixel;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic             calc;
    logic             border;
    logic             last;
  } cmd_t;

  typedef struct packed {
    logic [THR_W-1:0] threshold;
    logic             restart;
  } ctl_t;

endpackage

// File: rtl/sgn_cmd_queue.sv
module sgn_cmd_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  sgn_pkg::cmd_t data_i,
  output logic          full_o,
  output logic          valid_o,
  output sgn_pkg::cmd_t data_o,
  input  logic          pop_i
);
  import sgn_pkg::*;

  cmd_t                 mem_q [CMD_DEPTH];
  logic [CMD_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CMD_PTR_W:0]   count_q;
  logic                 do_push, do_pop;

  assign full_o  = (count_q == (CMD_PTR_W+1)'(CMD_DEPTH));
  assign valid_o = (count_q != '0);
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (do_pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
      if (do_push && !do_pop) count_q <= count_q + 1'b1;
      else if (!do_push && do_pop) count_q <= count_q - 1'b1;
    end
  end

endmodule

// File: rtl/sgn_front.sv
module sgn_front (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           push,
  output logic                           full,
  input  sgn_pkg::in_t                   in_i,
  input  logic                           cfg_we_i,
  input  logic [sgn_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [sgn_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output logic                           cmd_push_o,
  output sgn_pkg::cmd_t                  cmd_o,
  input  logic                           cmd_full_i,
  output sgn_pkg::ctl_t                  ctl_o
);
  import sgn_pkg::*;

  logic [SIZE_W-1:0] rows_q, cols_q;
  logic [THR_W-1:0]  thr_q;
  logic [ROW_W-1:0]  ld_row_q, rd_row_q, last_row;
  logic [COL_W-1:0]  ld_col_q, rd_col_q, last_col;
  logic              ready_q;
  logic              accept, is_load, is_read, restart;
  logic              ld_eol, ld_last, rd_eol, rd_last;

  function automatic logic [ROW_W-1:0] last_index(input logic [SIZE_W-1:0] v,
                                                  input int unsigned maxv);
    logic [ROW_W-1:0] r;
    if (v == '0) r = '0;
    else if (v > SIZE_W'(maxv)) r = ROW_W'(maxv - 1);
    else r = ROW_W'(v - 1'b1);
    return r;
  endfunction

  assign last_row = last_index(rows_q, MAX_ROWS);
  assign last_col = COL_W'(last_index(cols_q, MAX_COLS));

  assign full    = cmd_full_i;
  assign accept  = push && !cmd_full_i;
  assign is_load = accept && (in_i.op == OP_LOAD) && !ready_q;
  assign is_read = accept && (in_i.op == OP_READ) && ready_q;
  assign restart = cfg_we_i && ((cfg_idx_i == CFG_ROWS) || (cfg_idx_i == CFG_COLS));

  assign ld_eol  = (ld_col_q == last_col);
  assign ld_last = ld_eol && (ld_row_q == last_row);
  assign rd_eol  = (rd_col_q == last_col);
  assign rd_last = rd_eol && (rd_row_q == last_row);

  assign cmd_push_o = is_load || is_read;

  always_comb begin
    cmd_o         = '0;
    cmd_o.is_read = (in_i.op == OP_READ);
    cmd_o.pixel   = in_i.pixel;
    if (in_i.op == OP_READ) begin
      cmd_o.row    = rd_row_q;
      cmd_o.col    = rd_col_q;
      cmd_o.last   = rd_last;
      cmd_o.border = (rd_row_q == '0) || (rd_col_q == '0) || (rd_row_q == last_row) ||
                     rd_eol;
    end else begin
      cmd_o.row  = ld_row_q;
      cmd_o.col  = ld_col_q;
      cmd_o.last = ld_last;
      cmd_o.calc = (ld_row_q >= ROW_W'(2)) && (ld_col_q >= COL_W'(2));
    end
  end

  assign ctl_o.threshold = thr_q;
  assign ctl_o.restart   = restart;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q   <= SIZE_W'(MAX_ROWS);
      cols_q   <= SIZE_W'(MAX_COLS);
      thr_q    <= '0;
      ld_row_q <= '0;
      ld_col_q <= '0;
      rd_row_q <= '0;
      rd_col_q <= '0;
      ready_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_ROWS:   rows_q <= cfg_data_i[SIZE_W-1:0];
          CFG_COLS:   cols_q <= cfg_data_i[SIZE_W-1:0];
          CFG_THRESH: thr_q  <= cfg_data_i[THR_W-1:0];
          default: ;
        endcase
      end
      if (restart) begin
        ld_row_q <= '0;
        ld_col_q <= '0;
        rd_row_q <= '0;
        rd_col_q <= '0;
        ready_q  <= 1'b0;
      end else if (is_load) begin
        ld_col_q <= ld_eol ? '0 : ld_col_q + 1'b1;
        if (ld_eol) ld_row_q <= ld_row_q + 1'b1;
        if (ld_last) begin
          ld_row_q <= '0;
          ready_q  <= 1'b1;
        end
      end else if (is_read) begin
        rd_col_q <= rd_eol ? '0 : rd_col_q + 1'b1;
        if (rd_eol) rd_row_q <= rd_row_q + 1'b1;
        if (rd_last) begin
          rd_row_q <= '0;
          ready_q  <= 1'b0;
        end
      end
    end
  end

endmodule

// File: rtl/sgn_back.sv
module sgn_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cmd_valid_i,
  input  sgn_pkg::cmd_t cmd_i,
  output logic          cmd_pop_o,
  input  sgn_pkg::ctl_t ctl_i,
  output logic          empty,
  input  logic          pop,
  output sgn_pkg::res_t res_o
);
  import sgn_pkg::*;

  localparam int NST   = 17;
  localparam int DVD_W = GRAD_W + FRAC_W;
  localparam int REM_W = ROOT_W + 1;
  localparam int CNT_W = $clog2(DVD_W);
  localparam int QS_W  = FRAC_W + 1;
  localparam int E_W   = 2 * QS_W;
  localparam int T_W   = 2 * THR_W;

  typedef enum logic [NST-1:0] {
    ST_IDLE  = 17'b00000000000000001,
    ST_LRD   = 17'b00000000000000010,
    ST_LWIN  = 17'b00000000000000100,
    ST_LGRAD = 17'b00000000000001000,
    ST_LSQ1  = 17'b00000000000010000,
    ST_LSQ2  = 17'b00000000000100000,
    ST_RINIT = 17'b00000000001000000,
    ST_ROOT  = 17'b00000000010000000,
    ST_RRD   = 17'b00000000100000000,
    ST_RLAT  = 17'b00000001000000000,
    ST_RDIV  = 17'b00000010000000000,
    ST_RSQ1  = 17'b00000100000000000,
    ST_RSQ2  = 17'b00001000000000000,
    ST_RSQ3  = 17'b00010000000000000,
    ST_RTH   = 17'b00100000000000000,
    ST_OUT   = 17'b01000000000000000,
    ST_FIN   = 17'b10000000000000000
  } state_e;

  state_e state_q, state_d;

  logic [2*PIX_W-1:0]  line_mem [MAX_COLS];
  logic [2*PIX_W-1:0]  line_rd_q;
  logic [2*GRAD_W-1:0] grad_mem [MAX_ROWS*MAX_COLS];
  logic [2*GRAD_W-1:0] grad_rd_q;
  logic [PIX_W-1:0]    win_a_q [3];
  logic [PIX_W-1:0]    win_m_q [3];
  logic [PIX_W-1:0]    win_b_q [3];

  logic signed [GRAD_W-1:0] gd, gr, gd_q, gr_q, rd_d, rd_r;
  logic [SQ_W-1:0]          sq_q, sum, max_q;
  logic [SQ_W-1:0]          rem_q, res_q, bit_q, trial, rem_d, res_d;
  logic [ROOT_W-1:0]        root_q;
  logic [DVD_W-1:0]         dvd_q [2];
  logic [DVD_W-1:0]         dvd_d [2];
  logic [REM_W-1:0]         drem_q [2];
  logic [REM_W-1:0]         drem_d [2];
  logic [REM_W-1:0]         rem_sh [2];
  logic [CNT_W-1:0]         cnt_q;
  logic                     neg_q [2];
  logic [QS_W-1:0]          qd_q, qr_q, qd_sat, qr_sat;
  logic [E_W-1:0]           dsq_q, e_q;
  logic [T_W-1:0]           tsq;
  logic                     sup;
  logic signed [OUT_W-1:0]  vd, vr;
  logic                     out_valid_q, out_load;
  res_t                     out_q, pend_q;
  logic [2*PIX_W-1:0]       line_wr;

  function automatic logic signed [GRAD_W-1:0] ext(input logic [PIX_W-1:0] p);
    return $signed({(GRAD_W-PIX_W)'(0), p});
  endfunction

  function automatic logic [GRAD_W-1:0] mag(input logic signed [GRAD_W-1:0] g);
    return g[GRAD_W-1] ? GRAD_W'(-g) : GRAD_W'(g);
  endfunction

  function automatic logic [QS_W-1:0] sat(input logic [DVD_W-1:0] q);
    return (q > DVD_W'(Q14_ONE)) ? QS_W'(Q14_ONE) : q[QS_W-1:0];
  endfunction

  assign gd = (ext(win_b_q[0]) + (ext(win_b_q[1]) <<< 1) + ext(win_b_q[2])) -
              (ext(win_a_q[0]) + (ext(win_a_q[1]) <<< 1) + ext(win_a_q[2]));
  assign gr = (ext(win_a_q[2]) + (ext(win_m_q[2]) <<< 1) + ext(win_b_q[2])) -
              (ext(win_a_q[0]) + (ext(win_m_q[0]) <<< 1) + ext(win_b_q[0]));

  assign rd_d = cmd_i.border ? '0 : $signed(grad_rd_q[2*GRAD_W-1:GRAD_W]);
  assign rd_r = cmd_i.border ? '0 : $signed(grad_rd_q[GRAD_W-1:0]);

  assign sum = sq_q + SQ_W'(mag(gr_q)) * SQ_W'(mag(gr_q));

  assign trial = res_q + bit_q;
  always_comb begin
    if (rem_q >= trial) begin
      rem_d = rem_q - trial;
      res_d = (res_q >> 1) + bit_q;
    end else begin
      rem_d = rem_q;
      res_d = res_q >> 1;
    end
  end

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      rem_sh[l] = {drem_q[l][REM_W-2:0], dvd_q[l][DVD_W-1]};
      if (rem_sh[l] >= {1'b0, root_q}) begin
        drem_d[l] = rem_sh[l] - {1'b0, root_q};
        dvd_d[l]  = {dvd_q[l][DVD_W-2:0], 1'b1};
      end else begin
        drem_d[l] = rem_sh[l];
        dvd_d[l]  = {dvd_q[l][DVD_W-2:0], 1'b0};
      end
    end
  end

  assign qd_sat = sat(dvd_q[0]);
  assign qr_sat = sat(dvd_q[1]);
  assign tsq    = ctl_i.threshold * ctl_i.threshold;
  assign sup    = {e_q, 4'b0} < tsq;
  assign vd     = neg_q[0] ? -$signed({1'b0, qd_q}) : $signed({1'b0, qd_q});
  assign vr     = neg_q[1] ? -$signed({1'b0, qr_q}) : $signed({1'b0, qr_q});
  assign line_wr = {line_rd_q[PIX_W-1:0], cmd_i.pixel};

  assign out_load  = (state_q == ST_OUT) && (!out_valid_q || pop);
  assign cmd_pop_o = (state_q == ST_FIN);
  assign empty     = !out_valid_q;
  assign res_o     = out_q;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:  if (cmd_valid_i) state_d = cmd_i.is_read ? ST_RRD : ST_LRD;
      ST_LRD:   state_d = ST_LWIN;
      ST_LWIN:  state_d = ST_LGRAD;
      ST_LGRAD: state_d = cmd_i.calc ? ST_LSQ1 : (cmd_i.last ? ST_RINIT : ST_FIN);
      ST_LSQ1:  state_d = ST_LSQ2;
      ST_LSQ2:  state_d = cmd_i.last ? ST_RINIT : ST_FIN;
      ST_RINIT: state_d = ST_ROOT;
      ST_ROOT:  if (bit_q[0]) state_d = ST_FIN;
      ST_RRD:   state_d = ST_RLAT;
      ST_RLAT:  state_d = (root_q == '0) ? ST_OUT : ST_RDIV;
      ST_RDIV:  if (cnt_q == CNT_W'(DVD_W-1)) state_d = ST_RSQ1;
      ST_RSQ1:  state_d = ST_RSQ2;
      ST_RSQ2:  state_d = ST_RSQ3;
      ST_RSQ3:  state_d = ST_RTH;
      ST_RTH:   state_d = ST_OUT;
      ST_OUT:   if (out_load) state_d = ST_FIN;
      ST_FIN:   state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    line_rd_q <= line_mem[cmd_i.col];
    if (state_q == ST_LWIN) line_mem[cmd_i.col] <= line_wr;
    grad_rd_q <= grad_mem[{cmd_i.row, cmd_i.col}];
    if ((state_q == ST_LGRAD) && cmd_i.calc) begin
      grad_mem[{cmd_i.row - 1'b1, cmd_i.col - 1'b1}] <= {gd, gr};
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_LWIN: begin
        win_a_q[0] <= win_a_q[1];
        win_a_q[1] <= win_a_q[2];
        win_a_q[2] <= line_rd_q[2*PIX_W-1:PIX_W];
        win_m_q[0] <= win_m_q[1];
        win_m_q[1] <= win_m_q[2];
        win_m_q[2] <= line_rd_q[PIX_W-1:0];
        win_b_q[0] <= win_b_q[1];
        win_b_q[1] <= win_b_q[2];
        win_b_q[2] <= cmd_i.pixel;
      end
      ST_LGRAD: begin
        gd_q <= gd;
        gr_q <= gr;
      end
      ST_LSQ1: sq_q <= SQ_W'(mag(gd_q)) * SQ_W'(mag(gd_q));
      ST_RINIT: begin
        rem_q <= max_q;
        res_q <= '0;
        bit_q <= SQ_W'(1) << (SQ_W - 2);
      end
      ST_ROOT: begin
        rem_q <= rem_d;
        res_q <= res_d;
        bit_q <= bit_q >> 2;
      end
      ST_RLAT: begin
        dvd_q[0]  <= {mag(rd_d), FRAC_W'(0)};
        dvd_q[1]  <= {mag(rd_r), FRAC_W'(0)};
        drem_q[0] <= '0;
        drem_q[1] <= '0;
        neg_q[0]  <= rd_d[GRAD_W-1];
        neg_q[1]  <= rd_r[GRAD_W-1];
        cnt_q     <= '0;
        pend_q    <= '{grad_down: '0, grad_right: '0, suppressed: 1'b0,
                       frame_last: cmd_i.last};
      end
      ST_RDIV: begin
        dvd_q[0]  <= dvd_d[0];
        dvd_q[1]  <= dvd_d[1];
        drem_q[0] <= drem_d[0];
        drem_q[1] <= drem_d[1];
        cnt_q     <= cnt_q + 1'b1;
      end
      ST_RSQ1: begin
        qd_q <= qd_sat;
        qr_q <= qr_sat;
      end
      ST_RSQ2: dsq_q <= E_W'(qd_q) * E_W'(qd_q);
      ST_RSQ3: e_q <= dsq_q + E_W'(qr_q) * E_W'(qr_q);
      ST_RTH: begin
        pend_q.suppressed <= sup;
        pend_q.grad_down  <= sup ? '0 : vd;
        pend_q.grad_right <= sup ? '0 : vr;
      end
      default: ;
    endcase
    if (out_load) out_q <= pend_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      max_q       <= '0;
      root_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_load) out_valid_q <= 1'b1;
      else if (pop) out_valid_q <= 1'b0;
      if (ctl_i.restart || ((state_q == ST_FIN) && cmd_i.is_read && cmd_i.last)) begin
        max_q  <= '0;
        root_q <= '0;
      end else begin
        if ((state_q == ST_LSQ2) && (sum > max_q)) max_q <= sum;
        if ((state_q == ST_ROOT) && bit_q[0]) root_q <= res_d[ROOT_W-1:0];
      end
    end
  end

endmodule

// File: rtl/sobel_gradient_normalize_unit.sv
// Sobel gradient unit: load a frame of grey pixels in raster order (op load), then
// read one normalized gradient per pixel in raster order (op read). Items enter a
// 4-deep command queue; in the back end a load does a line buffer read, window
// shift, gradient and, once the window is full, two squaring steps; the last load
// also runs the bit-serial square root; a read runs the 25-step shared restoring
// divider on both components together, skipped for a zero root. Reads before the
// frame is complete and loads while results are pending are taken and dropped.
module sobel_gradient_normalize_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           push,
  output logic                           full,
  input  sgn_pkg::in_t                   in_i,
  output logic                           empty,
  input  logic                           pop,
  output sgn_pkg::res_t                  res_o,
  input  logic                           cfg_we_i,
  input  logic [sgn_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [sgn_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import sgn_pkg::*;

  cmd_t cmd_in, cmd_out;
  ctl_t ctl;
  logic cmd_push, cmd_full, cmd_valid, cmd_pop;

  sgn_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .in_i       (in_i),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cmd_push_o (cmd_push),
    .cmd_o      (cmd_in),
    .cmd_full_i (cmd_full),
    .ctl_o      (ctl)
  );

  sgn_cmd_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .data_i  (cmd_in),
    .full_o  (cmd_full),
    .valid_o (cmd_valid),
    .data_o  (cmd_out),
    .pop_i   (cmd_pop)
  );

  sgn_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd_out),
    .cmd_pop_o   (cmd_pop),
    .ctl_i       (ctl),
    .empty       (empty),
    .pop         (pop),
    .res_o       (res_o)
  );

endmodule
